>>> design/utf8_persian_token_scanner_assert.svh
// Assertion macros for the Persian token scanner checker.
// Include guard only; no other dependencies.
`ifndef UTF8_PERSIAN_TOKEN_SCANNER_ASSERT_SVH
`define UTF8_PERSIAN_TOKEN_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPS_ASSERT_IMP(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ups: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPS_ASSERT_NEXT(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ups: assertion failed");

`endif

>>> design/ups_pkg.sv
// Shared types, constants and character-class helpers for the scanner.
// No dependencies; imported by every scanner module.
package ups_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int MAX_TOKEN_CHARS   = 256;
  localparam int MAX_NUMBER_DIGITS = 128;
  localparam int COUNT_CAP         = 511;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);

  typedef enum logic [3:0] {
    TK_IDENT    = 4'd0,
    TK_NUMBER   = 4'd1,
    TK_FUNC_KW  = 4'd2,
    TK_RET_KW   = 4'd3,
    TK_LBRACE   = 4'd4,
    TK_RBRACE   = 4'd5,
    TK_LPAREN   = 4'd6,
    TK_RPAREN   = 4'd7,
    TK_PLUS     = 4'd8,
    TK_MINUS    = 4'd9,
    TK_EOF      = 4'd10,
    TK_BAD_CHAR = 4'd11,
    TK_BAD_ENC  = 4'd12
  } tok_kind_t;

  localparam logic [20:0] CH_LBRACE = 21'h7B;
  localparam logic [20:0] CH_RBRACE = 21'h7D;
  localparam logic [20:0] CH_LPAREN = 21'h28;
  localparam logic [20:0] CH_RPAREN = 21'h29;
  localparam logic [20:0] CH_PLUS   = 21'h2B;
  localparam logic [20:0] CH_MINUS  = 21'h2D;
  localparam logic [20:0] CH_NL     = 21'h0A;
  localparam logic [20:0] CH_SP     = 21'h20;
  localparam logic [20:0] CH_TAB    = 21'h09;
  localparam logic [20:0] CH_CR     = 21'h0D;
  localparam logic [20:0] CH_BEL    = 21'h07;
  localparam logic [20:0] CH_USCORE = 21'h5F;

  localparam int KW_FUNC_LEN = 6;
  localparam int KW_RET_LEN  = 5;
  localparam logic [20:0] KW_FUNC [KW_FUNC_LEN] =
    '{21'h639, 21'h645, 21'h644, 21'h6A9, 21'h631, 21'h62F};
  localparam logic [20:0] KW_RET [KW_RET_LEN] =
    '{21'h628, 21'h631, 21'h6AF, 21'h634, 21'h62A};

  // Decoded character event, one per accepted byte at most.
  typedef struct packed {
    logic        chr;
    logic        enc_err;
    logic        eot;
    logic [20:0] cp;
    logic [2:0]  nbytes;
  } ev_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [8:0]  len;
    logic [15:0] sl;
    logic [15:0] sc;
    logic [15:0] el;
    logic [15:0] ec;
    logic [20:0] cp;
    logic        last;
  } res_t;

  function automatic logic is_digit_cp(input logic [20:0] c);
    return (c >= 21'h6F0) && (c <= 21'h6F9);
  endfunction

  function automatic logic is_alpha_cp(input logic [20:0] c);
    return ((c >= 21'h622) && (c <= 21'h6CC)) || (c == CH_USCORE);
  endfunction

  function automatic logic kw_func_hit(input logic [8:0] p, input logic [20:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KW_FUNC_LEN; i++) begin
      if (p == 9'(i) && c == KW_FUNC[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic kw_ret_hit(input logic [8:0] p, input logic [20:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KW_RET_LEN; i++) begin
      if (p == 9'(i) && c == KW_RET[i]) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

>>> design/utf8_persian_token_scanner.sv
// Top level of the UTF-8 Persian token scanner.
// Depends on ups_pkg, ups_utf8_dec, ups_lexer and ups_res_queue.

// The scanner takes one byte of UTF-8 text per transaction and returns
// tokens: identifiers (with the two keywords recognized), Persian-digit
// numbers, braces, parentheses, plus, minus, bad characters, and a final EOF
// or bad-encoding token after which it stays silent until reset. It accepts
// one byte per clock while the result queue has room: an accepted byte sits
// in an input register while the decoder and token builder work on it, and
// its tokens land in a four-entry result queue whose head drives the result
// port. A byte yields zero, one or two tokens; the result port drains one
// token per cycle while out_ready is high, and input stalls only while the
// queue holds more than two tokens. Line and column counts start at zero,
// columns count bytes, and both saturate at 2^POSITION_BITS-1 (the low 16
// bits are shown).
module utf8_persian_token_scanner import ups_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [8:0]  out_char_length,
  output logic [15:0] out_start_line,
  output logic [15:0] out_start_column,
  output logic [15:0] out_end_line,
  output logic [15:0] out_end_column,
  output logic [20:0] out_code_point,
  output logic        out_last_of_run
);

  // input register stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eot_r;

  logic       fire;     // byte in the input register is processed this cycle
  logic       q_room;
  ev_t        ev;
  res_t       res_a, res_b, head;
  logic [1:0] res_cnt;

  // the queue must hold both tokens a byte can produce
  assign fire     = s1_valid_r && q_room;
  assign in_ready = !s1_valid_r || fire;

  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_eot_r  <= in_end_of_text;
    end
  end

  // decoder gates its event with fire and its halt flag
  ups_utf8_dec u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (s1_byte_r),
    .eot       (s1_eot_r),
    .ev        (ev)
  );

  ups_lexer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .ev      (ev),
    .res_a   (res_a),
    .res_b   (res_b),
    .res_cnt (res_cnt)
  );

  // res_cnt is zero unless fire, since ev is empty otherwise
  ups_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_a      (res_a),
    .wr_b      (res_b),
    .wr_cnt    (res_cnt),
    .room      (q_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_token_kind   = head.kind;
  assign out_char_length  = head.len;
  assign out_start_line   = head.sl;
  assign out_start_column = head.sc;
  assign out_end_line     = head.el;
  assign out_end_column   = head.ec;
  assign out_code_point   = head.cp;
  assign out_last_of_run  = head.last;

endmodule

>>> design/ups_utf8_dec.sv
// UTF-8 decoder: assembles code points and flags encoding errors and end of text.
// Depends on ups_pkg (ev_t).
module ups_utf8_dec import ups_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] text_byte,
  input  logic       eot,
  output ev_t        ev
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        halted_r, halted_nxt;

  logic [20:0] acc_shift;
  logic [1:0]  pend_dec;
  logic [2:0]  cnt_inc;
  logic        bad_cp;

  assign acc_shift = {acc_r[14:0], text_byte[5:0]};
  assign pend_dec  = pend_r - 2'd1;
  assign cnt_inc   = cnt_r + 3'd1;
  // overlong, surrogate or out-of-range value on the final byte
  assign bad_cp = (cnt_inc == 3'd3 && acc_shift < 21'h800) ||
                  (cnt_inc == 3'd4 && acc_shift < 21'h10000) ||
                  (acc_shift >= 21'hD800 && acc_shift <= 21'hDFFF) ||
                  (acc_shift > 21'h10FFFF);

  always_comb begin
    ev         = '0;
    pend_nxt   = pend_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    if (fire && !halted_r) begin
      if (eot) begin
        if (pend_r != 2'd0) begin
          ev.enc_err = 1'b1;
          pend_nxt   = 2'd0;
        end else begin
          ev.eot = 1'b1;
        end
        halted_nxt = 1'b1;
      end else if (pend_r == 2'd0) begin
        if (!text_byte[7]) begin
          ev.chr    = 1'b1;
          ev.cp     = {13'b0, text_byte};
          ev.nbytes = 3'd1;
        end else if (text_byte inside {[8'hC2:8'hDF]}) begin
          acc_nxt  = {16'b0, text_byte[4:0]};
          pend_nxt = 2'd1;
          cnt_nxt  = 3'd1;
        end else if (text_byte inside {[8'hE0:8'hEF]}) begin
          acc_nxt  = {17'b0, text_byte[3:0]};
          pend_nxt = 2'd2;
          cnt_nxt  = 3'd1;
        end else if (text_byte inside {[8'hF0:8'hF4]}) begin
          acc_nxt  = {18'b0, text_byte[2:0]};
          pend_nxt = 2'd3;
          cnt_nxt  = 3'd1;
        end else begin
          ev.enc_err = 1'b1;
          halted_nxt = 1'b1;
        end
      end else if (text_byte[7:6] != 2'b10) begin
        ev.enc_err = 1'b1;
        halted_nxt = 1'b1;
        pend_nxt   = 2'd0;
      end else begin
        acc_nxt  = acc_shift;
        pend_nxt = pend_dec;
        cnt_nxt  = cnt_inc;
        if (pend_dec == 2'd0) begin
          if (bad_cp) begin
            ev.enc_err = 1'b1;
            halted_nxt = 1'b1;
          end else begin
            ev.chr    = 1'b1;
            ev.cp     = acc_shift;
            ev.nbytes = cnt_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 2'd0;
      acc_r    <= '0;
      cnt_r    <= 3'd0;
      halted_r <= 1'b0;
    end else begin
      pend_r   <= pend_nxt;
      acc_r    <= acc_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> design/ups_lexer.sv
// Token builder: tracks position and the pending number or identifier,
// and forms up to two tokens per decoded event. Depends on ups_pkg.
module ups_lexer import ups_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  ev_t        ev,
  output res_t       res_a,
  output res_t       res_b,
  output logic [1:0] res_cnt
);

  localparam int PW1 = POSITION_BITS + 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [8:0] NUM_LIM =
    9'((MAX_NUMBER_DIGITS > COUNT_CAP) ? COUNT_CAP : MAX_NUMBER_DIGITS);
  localparam logic [8:0] ID_LIM =
    9'((MAX_TOKEN_CHARS > COUNT_CAP) ? COUNT_CAP : MAX_TOKEN_CHARS);

  typedef enum logic [1:0] {MODE_NONE, MODE_NUMBER, MODE_IDENT} mode_t;

  mode_t                    mode_r, mode_nxt;
  logic [8:0]               cnt_r, cnt_nxt;
  logic [1:0]               kw_r, kw_nxt;
  logic [POSITION_BITS-1:0] tsl_r, tsl_nxt, tsc_r, tsc_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt, col_r, col_nxt;

  logic [PW1-1:0]           col_sum, line_sum;
  logic [POSITION_BITS-1:0] col_adv, line_inc;
  logic [8:0]               lim;
  logic                     is_dig, is_alp, is_nl, is_ws, cont;
  logic                     flush_en, sec_en;
  res_t                     flush_res, sec_res;

  function automatic logic [15:0] to16(input logic [POSITION_BITS-1:0] v);
    logic [POSITION_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  assign col_sum  = {1'b0, col_r} + PW1'(ev.nbytes);
  assign col_adv  = col_sum[POSITION_BITS] ? POS_MAX : col_sum[POSITION_BITS-1:0];
  assign line_sum = {1'b0, line_r} + PW1'(1);
  assign line_inc = line_sum[POSITION_BITS] ? POS_MAX : line_sum[POSITION_BITS-1:0];
  assign lim      = (mode_r == MODE_NUMBER) ? NUM_LIM : ID_LIM;

  assign is_dig = is_digit_cp(ev.cp);
  assign is_alp = is_alpha_cp(ev.cp);
  assign is_nl  = (ev.cp == CH_NL);
  assign is_ws  = (ev.cp == CH_SP) || (ev.cp == CH_TAB) || (ev.cp == CH_CR) ||
                  (ev.cp == CH_BEL);
  assign cont   = ev.chr && ((mode_r == MODE_NUMBER && is_dig) ||
                             (mode_r == MODE_IDENT && (is_alp || is_dig)));

  // pending token closes on any non-extending character, error or end mark
  assign flush_en = ((ev.chr && !cont) || ev.enc_err || ev.eot) && (mode_r != MODE_NONE);
  assign sec_en   = ev.enc_err || ev.eot ||
                    (ev.chr && !cont && !is_nl && !is_ws && !is_dig && !is_alp);

  always_comb begin
    flush_res = '0;
    if (mode_r == MODE_NUMBER) begin
      flush_res.kind = TK_NUMBER;
    end else if (kw_r[0] && cnt_r == 9'(KW_FUNC_LEN)) begin
      flush_res.kind = TK_FUNC_KW;
    end else if (kw_r[1] && cnt_r == 9'(KW_RET_LEN)) begin
      flush_res.kind = TK_RET_KW;
    end else begin
      flush_res.kind = TK_IDENT;
    end
    flush_res.len  = cnt_r;
    flush_res.sl   = to16(tsl_r);
    flush_res.sc   = to16(tsc_r);
    flush_res.el   = to16(line_r);
    flush_res.ec   = to16(col_r);
    flush_res.cp   = '0;
    flush_res.last = !sec_en;
  end

  always_comb begin
    sec_res      = '0;
    sec_res.sl   = to16(line_r);
    sec_res.sc   = to16(col_r);
    sec_res.el   = to16(line_r);
    sec_res.last = 1'b1;
    if (ev.enc_err) begin
      sec_res.kind = TK_BAD_ENC;
      sec_res.ec   = to16(col_r);
    end else if (ev.eot) begin
      sec_res.kind = TK_EOF;
      sec_res.ec   = to16(col_r);
    end else begin
      case (ev.cp)
        CH_LBRACE: sec_res.kind = TK_LBRACE;
        CH_RBRACE: sec_res.kind = TK_RBRACE;
        CH_LPAREN: sec_res.kind = TK_LPAREN;
        CH_RPAREN: sec_res.kind = TK_RPAREN;
        CH_PLUS:   sec_res.kind = TK_PLUS;
        CH_MINUS:  sec_res.kind = TK_MINUS;
        default:   sec_res.kind = TK_BAD_CHAR;
      endcase
      // bad chars report their byte count
      sec_res.len = (sec_res.kind == TK_BAD_CHAR) ? {6'b0, ev.nbytes} : 9'd1;
      sec_res.ec  = to16(col_adv);
      sec_res.cp  = ev.cp;
    end
  end

  assign res_a   = flush_en ? flush_res : sec_res;
  assign res_b   = sec_res;
  assign res_cnt = {1'b0, flush_en} + {1'b0, sec_en};

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    kw_nxt   = kw_r;
    tsl_nxt  = tsl_r;
    tsc_nxt  = tsc_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (ev.chr) begin
      if (cont) begin
        if (mode_r == MODE_IDENT) begin
          kw_nxt = kw_r & {kw_ret_hit(cnt_r, ev.cp), kw_func_hit(cnt_r, ev.cp)};
        end
        if (cnt_r < lim) cnt_nxt = cnt_r + 9'd1;
        col_nxt = col_adv;
      end else begin
        mode_nxt = MODE_NONE;
        if (is_nl) begin
          line_nxt = line_inc;
          col_nxt  = '0;
        end else begin
          col_nxt = col_adv;
          if (is_dig) begin
            mode_nxt = MODE_NUMBER;
            cnt_nxt  = 9'd1;
            kw_nxt   = 2'b11;
            tsl_nxt  = line_r;
            tsc_nxt  = col_r;
          end else if (is_alp) begin
            mode_nxt = MODE_IDENT;
            cnt_nxt  = 9'd1;
            kw_nxt   = {kw_ret_hit(9'd0, ev.cp), kw_func_hit(9'd0, ev.cp)};
            tsl_nxt  = line_r;
            tsc_nxt  = col_r;
          end
        end
      end
    end else if (ev.enc_err || ev.eot) begin
      mode_nxt = MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NONE;
      cnt_r  <= 9'd0;
      kw_r   <= 2'b11;
      tsl_r  <= '0;
      tsc_r  <= '0;
      line_r <= '0;
      col_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      kw_r   <= kw_nxt;
      tsl_r  <= tsl_nxt;
      tsc_r  <= tsc_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

>>> design/ups_res_queue.sv
// Result queue: takes up to two tokens per cycle, hands out one per cycle while out_ready is high.
// Depends on ups_pkg (res_t, RQ_DEPTH).
module ups_res_queue import ups_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       wr_a,
  input  res_t       wr_b,
  input  logic [1:0] wr_cnt,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       head
);

  localparam logic [RQ_AW:0] ROOM_MAX = (RQ_AW+1)'(RQ_DEPTH - 2);

  res_t             mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [RQ_AW:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign room      = (cnt_r <= ROOM_MAX);
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_p1 = wr_ptr_r + RQ_AW'(1);

  assign wr_ptr_nxt = wr_ptr_r + RQ_AW'(wr_cnt);
  assign rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop);
  assign cnt_nxt    = cnt_r + (RQ_AW+1)'(wr_cnt) - (RQ_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wr_ptr_r] <= wr_a;
    if (wr_cnt == 2'd2) mem_r[wr_ptr_p1] <= wr_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/ups_checker.sv
// Port-level checker for the token scanner, bound to the top level.
// Depends on ups_pkg and utf8_persian_token_scanner_assert.svh.
`include "utf8_persian_token_scanner_assert.svh"

module ups_checker import ups_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [8:0]  out_char_length,
  input logic [15:0] out_start_line,
  input logic [15:0] out_start_column,
  input logic [15:0] out_end_line,
  input logic [15:0] out_end_column,
  input logic [20:0] out_code_point,
  input logic        out_last_of_run
);

  // stalled result holds
  `UPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_token_kind) && $stable(out_start_column))

  // second token of a byte is queued together with the first
  `UPS_ASSERT_NEXT(a_run_follows, clk, rst_n, out_valid && out_ready && !out_last_of_run, out_valid)

  // nothing after the closing EOF or bad-encoding token
  `UPS_ASSERT_NEXT(a_quiet_after_end, clk, rst_n, out_valid && out_ready && (out_token_kind == TK_EOF || out_token_kind == TK_BAD_ENC), !out_valid)

  `UPS_ASSERT_IMP(a_end_marker, clk, rst_n, out_valid && (out_token_kind == TK_EOF || out_token_kind == TK_BAD_ENC), out_char_length == 9'd0 && out_code_point == 21'd0 && out_start_column == out_end_column && out_last_of_run)

  // tokens never span lines
  `UPS_ASSERT_IMP(a_same_line, clk, rst_n, out_valid, out_end_line == out_start_line)

endmodule

bind utf8_persian_token_scanner ups_checker u_ups_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_persian_token_scanner: UTF-8 text in, tokens out.
// Depends on ups_pkg for token kinds, character constants, keywords and limits.

import ups_pkg::*;

typedef enum logic [1:0] {RUN_NONE, RUN_NUMBER, RUN_WORD} run_e;

// Predicts the token stream from accepted bytes and checks what the block returns.
class scan_checker;
  res_t        tokens_due[$];
  int unsigned fails;

  logic [1:0]  cont_left;
  logic [20:0] cp_acc;
  logic [2:0]  seq_len;
  run_e        run;
  int unsigned run_chars, run_line, run_col;
  int unsigned line_no, col_no;
  logic [1:0]  kw_alive;   // bit 0: function keyword, bit 1: return keyword
  bit          stopped;
  res_t        made [2];
  int unsigned made_n;

  function new();
    cont_left = 0; cp_acc = 0; seq_len = 0;
    run = RUN_NONE; run_chars = 0; run_line = 0; run_col = 0;
    line_no = 0; col_no = 0; kw_alive = 2'b11;
    stopped = 0; fails = 0; made_n = 0;
  endfunction

  function int unsigned clip(int unsigned v);
    return (v > 65535) ? 65535 : v;
  endfunction

  // At most two tokens per byte.
  function void put(tok_kind_t kind, int unsigned len, int unsigned sl, int unsigned sc,
                    int unsigned el, int unsigned ec, logic [20:0] cp);
    if (made_n >= 2) return;
    made[made_n].kind = kind;
    made[made_n].len  = 9'(len);
    made[made_n].sl   = 16'(sl);
    made[made_n].sc   = 16'(sc);
    made[made_n].el   = 16'(el);
    made[made_n].ec   = 16'(ec);
    made[made_n].cp   = cp;
    made[made_n].last = 1'b0;
    made_n++;
  endfunction

  function void grow(logic [20:0] c);
    int unsigned cap;
    if (run == RUN_WORD) begin
      if (run_chars >= KW_FUNC_LEN || KW_FUNC[run_chars] != c) kw_alive[0] = 1'b0;
      if (run_chars >= KW_RET_LEN || KW_RET[run_chars] != c) kw_alive[1] = 1'b0;
    end
    cap = (run == RUN_NUMBER) ? MAX_NUMBER_DIGITS : MAX_TOKEN_CHARS;
    if (run_chars < cap) run_chars++;
  endfunction

  function void open_run(run_e m, logic [20:0] c, int unsigned col0);
    run = m;
    run_chars = 0;
    kw_alive = 2'b11;
    run_line = line_no;
    run_col = col0;
    grow(c);
  endfunction

  function void close_run(int unsigned el, int unsigned ec);
    tok_kind_t kind;
    if (run == RUN_NONE) return;
    if (run == RUN_NUMBER) kind = TK_NUMBER;
    else if (kw_alive[0] && run_chars == KW_FUNC_LEN) kind = TK_FUNC_KW;
    else if (kw_alive[1] && run_chars == KW_RET_LEN) kind = TK_RET_KW;
    else kind = TK_IDENT;
    put(kind, run_chars, run_line, run_col, el, ec, 21'd0);
    run = RUN_NONE;
  endfunction

  function void enc_fail();
    close_run(line_no, col_no);
    put(TK_BAD_ENC, 0, line_no, col_no, line_no, col_no, 21'd0);
    stopped = 1'b1;
    cont_left = 0;
  endfunction

  function void scan_char(logic [20:0] c, int unsigned n);
    int unsigned col0;
    tok_kind_t   kind;
    bit          digit, letter;
    col0 = col_no;
    digit = c inside {[21'h6F0:21'h6F9]};
    letter = c inside {[21'h622:21'h6CC], CH_USCORE};
    if ((run == RUN_NUMBER && digit) || (run == RUN_WORD && (letter || digit))) begin
      grow(c);
      col_no = clip(col0 + n);
      return;
    end
    // the terminating character is scanned on its own after the flush
    close_run(line_no, col0);
    if (c == CH_NL) begin
      line_no = clip(line_no + 1);
      col_no = 0;
      return;
    end
    col_no = clip(col0 + n);
    if (c inside {CH_SP, CH_TAB, CH_CR, CH_BEL}) return;
    if (digit || letter) begin
      open_run(digit ? RUN_NUMBER : RUN_WORD, c, col0);
      return;
    end
    case (c)
      CH_LBRACE: kind = TK_LBRACE;
      CH_RBRACE: kind = TK_RBRACE;
      CH_LPAREN: kind = TK_LPAREN;
      CH_RPAREN: kind = TK_RPAREN;
      CH_PLUS:   kind = TK_PLUS;
      CH_MINUS:  kind = TK_MINUS;
      default:   kind = TK_BAD_CHAR;
    endcase
    put(kind, (kind == TK_BAD_CHAR) ? n : 1, line_no, col0, line_no, col_no, c);
  endfunction

  // One accepted input transaction.
  function void note_byte(logic [7:0] b, logic eot);
    logic [20:0] c;
    made_n = 0;
    if (stopped) return;
    if (eot) begin
      if (cont_left != 0) enc_fail();
      else begin
        close_run(line_no, col_no);
        put(TK_EOF, 0, line_no, col_no, line_no, col_no, 21'd0);
        stopped = 1'b1;
      end
    end else if (cont_left == 0) begin
      if (b < 8'h80) scan_char({13'd0, b}, 1);
      else if (b >= 8'hC2 && b <= 8'hDF) begin
        cp_acc = 21'(b[4:0]); cont_left = 2'd1; seq_len = 3'd1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        cp_acc = 21'(b[3:0]); cont_left = 2'd2; seq_len = 3'd1;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        cp_acc = 21'(b[2:0]); cont_left = 2'd3; seq_len = 3'd1;
      end else enc_fail();
    end else if (b[7:6] != 2'b10) enc_fail();
    else begin
      cp_acc = {cp_acc[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      seq_len = seq_len + 3'd1;
      if (cont_left == 0) begin
        c = cp_acc;
        if ((seq_len == 3 && c < 21'h800) || (seq_len == 4 && c < 21'h10000) ||
            (c >= 21'hD800 && c <= 21'hDFFF) || c > 21'h10FFFF) enc_fail();
        else scan_char(c, seq_len);
      end
    end
    if (made_n > 0) made[made_n - 1].last = 1'b1;
    for (int i = 0; i < made_n; i++) tokens_due.push_back(made[i]);
  endfunction

  function void report(string why, res_t want, res_t got);
    fails++;
    if (fails <= 10)
      $display({"token mismatch (%s):\n",
                "  expected kind %0d len %0d start %0d:%0d end %0d:%0d cp %0h last %0b\n",
                "  actual   kind %0d len %0d start %0d:%0d end %0d:%0d cp %0h last %0b"},
               why, want.kind, want.len, want.sl, want.sc, want.el, want.ec, want.cp,
               want.last, got.kind, got.len, got.sl, got.sc, got.el, got.ec, got.cp,
               got.last);
  endfunction

  // One accepted result transaction.
  function void match_token(res_t got);
    res_t want;
    if (tokens_due.size() == 0) begin
      report("no token was due", '0, got);
      return;
    end
    want = tokens_due.pop_front();
    if (want.kind !== got.kind || want.len !== got.len || want.sl !== got.sl ||
        want.sc !== got.sc || want.el !== got.el || want.ec !== got.ec ||
        want.cp !== got.cp || want.last !== got.last)
      report("field differs", want, got);
  endfunction
endclass

module testbench;

  typedef enum {KW_EXACT, KW_PREFIX, KW_LONGER, KW_ALTERED} kw_twist_e;
  typedef enum {END_CLEAN, END_CUT_SEQ, END_STRAY_CONT, END_BAD_LEAD, END_BROKEN_SEQ,
                END_OVERLONG3, END_OVERLONG4, END_SURROGATE, END_TOO_BIG} ending_e;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 800;
  localparam int unsigned HOLD_AFTER = 40;      // results seen before the long stall
  localparam int unsigned HOLD_CYCLES = 400;

  localparam logic [20:0] PUNCT [6] =
    '{CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS};
  localparam logic [20:0] BLANKS [4] = '{CH_SP, CH_TAB, CH_CR, CH_BEL};

  // Opening text: both keywords, every punctuation mark, every blank, digit and
  // letter range edges, underscore, NUL/DEL and an edge of each UTF-8 length.
  localparam logic [20:0] OPENING [36] = '{
    21'h639, 21'h645, 21'h644, 21'h6A9, 21'h631, 21'h62F,
    CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_SP,
    21'h628, 21'h631, 21'h6AF, 21'h634, 21'h62A,
    CH_TAB, 21'h6F0, 21'h6F9, 21'h622, 21'h6CC,
    CH_USCORE, 21'h6F5, CH_PLUS, CH_MINUS, CH_CR,
    CH_BEL, CH_RBRACE, CH_NL, 21'h000, 21'h07F,
    21'h621, 21'h6CD, 21'h080, 21'hFFFF, 21'h10FFFF, CH_NL};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_token_kind;
  logic [8:0]  out_char_length;
  logic [15:0] out_start_line;
  logic [15:0] out_start_column;
  logic [15:0] out_end_line;
  logic [15:0] out_end_column;
  logic [20:0] out_code_point;
  logic        out_last_of_run;

  scan_checker board;
  int unsigned send_gap_max = 12;   // 0 gives back-to-back input transactions
  int unsigned sent;
  int unsigned cycle_count = 0;

  utf8_persian_token_scanner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_char_length  (out_char_length),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_end_line     (out_end_line),
    .out_end_column   (out_end_column),
    .out_code_point   (out_code_point),
    .out_last_of_run  (out_last_of_run)
  );

  always #10 clk = ~clk;

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // One input transaction. Valid is lowered only when a gap is drawn, so a
  // back-to-back transaction never sees valid dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, eot);
    sent++;
  endtask

  // UTF-8 encode one code point and send its bytes.
  task automatic send_char(input logic [20:0] c);
    if (c < 21'h80) send_byte(c[7:0], 1'b0);
    else if (c < 21'h800) begin
      send_byte({3'b110, c[10:6]}, 1'b0);
      send_byte({2'b10, c[5:0]}, 1'b0);
    end else if (c < 21'h10000) begin
      send_byte({4'b1110, c[15:12]}, 1'b0);
      send_byte({2'b10, c[11:6]}, 1'b0);
      send_byte({2'b10, c[5:0]}, 1'b0);
    end else begin
      send_byte({5'b11110, c[20:18]}, 1'b0);
      send_byte({2'b10, c[17:12]}, 1'b0);
      send_byte({2'b10, c[11:6]}, 1'b0);
      send_byte({2'b10, c[5:0]}, 1'b0);
    end
  endtask

  function automatic logic [20:0] pick_letter();
    return ($urandom_range(0, 7) == 0) ? CH_USCORE : 21'($urandom_range('h622, 'h6CC));
  endfunction

  function automatic logic [20:0] pick_digit();
    return 21'($urandom_range('h6F0, 'h6F9));
  endfunction

  function automatic logic [7:0] pick_cont();
    return 8'($urandom_range('h80, 'hBF));
  endfunction

  // Any valid character that is neither a token character nor a blank;
  // the Arabic block around the letters is favored.
  function automatic logic [20:0] odd_char();
    logic [20:0] c;
    do begin
      case ($urandom_range(0, 4))
        0: c = 21'($urandom_range(0, 'h7F));
        1: c = 21'($urandom_range('h80, 'h7FF));
        2: c = 21'($urandom_range('h600, 'h6FF));
        3: c = 21'($urandom_range('h800, 'hFFFF));
        default: c = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
    end while (c inside {[21'h622:21'h6CC], [21'h6F0:21'h6F9], [21'hD800:21'hDFFF],
                         CH_USCORE, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
                         CH_PLUS, CH_MINUS, CH_NL, CH_SP, CH_TAB, CH_CR, CH_BEL});
    return c;
  endfunction

  // Identifier: a letter, then letters and Persian digits.
  task automatic send_word(input int unsigned n);
    send_char(pick_letter());
    for (int i = 1; i < n; i++)
      send_char(($urandom_range(0, 4) == 0) ? pick_digit() : pick_letter());
  endtask

  // Keyword spelled exactly, cut short, run on, or with one character swapped.
  task automatic send_keyword(input bit is_ret, input kw_twist_e twist);
    int unsigned n, cut, swap;
    logic [20:0] c;
    n = is_ret ? KW_RET_LEN : KW_FUNC_LEN;
    cut = (twist == KW_PREFIX) ? $urandom_range(1, n - 1) : n;
    swap = (twist == KW_ALTERED) ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < cut; i++) begin
      c = is_ret ? KW_RET[i] : KW_FUNC[i];
      if (i == swap) c = pick_letter();
      send_char(c);
    end
    if (twist == KW_LONGER) send_char(($urandom_range(0, 1) == 0) ? pick_letter() : pick_digit());
  endtask

  // Result side: random ready gaps, with stretches of none, and one long hold
  // while the sender keeps offering so the result queue fills and in_ready drops.
  initial begin
    int unsigned gap, seen, ready_gap_max;
    res_t got;
    out_ready <= 1'b0;
    seen = 0;
    ready_gap_max = 12;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen % 64 == 0) ready_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      gap = $urandom_range(0, ready_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.kind = tok_kind_t'(out_token_kind);
      got.len  = out_char_length;
      got.sl   = out_start_line;
      got.sc   = out_start_column;
      got.el   = out_end_line;
      got.ec   = out_end_column;
      got.cp   = out_code_point;
      got.last = out_last_of_run;
      board.match_token(got);
      seen++;
      if (seen == HOLD_AFTER) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned pick;
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_text_byte <= 8'h00;
    in_end_of_text <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (OPENING[i]) send_char(OPENING[i]);

    // Random text, mostly well-formed tokens with random content.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 15) == 0) send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      pick = $urandom_range(0, 99);
      if (pick < 30) send_word($urandom_range(1, 12));
      else if (pick < 38) send_keyword($urandom_range(0, 1), KW_EXACT);
      else if (pick < 46) send_keyword($urandom_range(0, 1), kw_twist_e'($urandom_range(1, 3)));
      else if (pick < 60) repeat ($urandom_range(1, 10)) send_char(pick_digit());
      else if (pick < 74) send_char(PUNCT[$urandom_range(0, 5)]);
      else if (pick < 86) repeat ($urandom_range(1, 3)) send_char(BLANKS[$urandom_range(0, 3)]);
      else if (pick < 91) send_char(CH_NL);
      else send_char(odd_char());
    end
    send_gap_max = 12;

    // Token lengths past their caps.
    send_word(300);
    send_char(CH_SP);
    repeat (150) send_char(pick_digit());
    send_char(CH_PLUS);

    // Halting ending; the seed picks one per run, sometimes with a token pending.
    case ($urandom_range(0, 2))
      0: send_word($urandom_range(1, 6));
      1: repeat ($urandom_range(1, 4)) send_char(pick_digit());
      default: ;
    endcase
    case (ending_e'($urandom_range(0, 8)))
      END_CLEAN: send_byte(8'($urandom), 1'b1);
      END_CUT_SEQ: begin
        case ($urandom_range(0, 2))
          0: send_byte(8'($urandom_range('hC2, 'hDF)), 1'b0);
          1: begin
            send_byte(8'($urandom_range('hE1, 'hEC)), 1'b0);
            repeat ($urandom_range(0, 1)) send_byte(pick_cont(), 1'b0);
          end
          default: begin
            send_byte(8'($urandom_range('hF1, 'hF3)), 1'b0);
            repeat ($urandom_range(0, 2)) send_byte(pick_cont(), 1'b0);
          end
        endcase
        send_byte(8'($urandom), 1'b1);
      end
      END_STRAY_CONT: send_byte(pick_cont(), 1'b0);
      END_BAD_LEAD: send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range('hC0, 'hC1))
                                                          : 8'($urandom_range('hF5, 'hFF)),
                              1'b0);
      END_BROKEN_SEQ: begin
        send_byte(8'($urandom_range('hC2, 'hEC)), 1'b0);
        send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 'h7F))
                                              : 8'($urandom_range('hC0, 'hFF)), 1'b0);
      end
      END_OVERLONG3: begin
        send_byte(8'hE0, 1'b0);
        send_byte(8'($urandom_range('h80, 'h9F)), 1'b0);
        send_byte(pick_cont(), 1'b0);
      end
      END_OVERLONG4: begin
        send_byte(8'hF0, 1'b0);
        send_byte(8'($urandom_range('h80, 'h8F)), 1'b0);
        send_byte(pick_cont(), 1'b0);
        send_byte(pick_cont(), 1'b0);
      end
      END_SURROGATE: begin
        send_byte(8'hED, 1'b0);
        send_byte(8'($urandom_range('hA0, 'hBF)), 1'b0);
        send_byte(pick_cont(), 1'b0);
      end
      default: begin
        send_byte(8'hF4, 1'b0);
        send_byte(8'($urandom_range('h90, 'hBF)), 1'b0);
        send_byte(pick_cont(), 1'b0);
        send_byte(pick_cont(), 1'b0);
      end
    endcase

    // Halted: anything further must stay silent.
    repeat (12) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    in_valid <= 1'b0;

    while (board.tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.fails == 0 && board.tokens_due.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
